/* hdl/sacm_pkg.sv */
// ---------------------------------------------------------------------------
// sacm_pkg: shared types and constants for the set-associative cache model
// Holds the config register indexes, counter width, replace modes and a saturating increment.
// ---------------------------------------------------------------------------
package sacm_pkg;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE  = 1'd1;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction
endpackage

/* hdl/sacm_if.sv */
// ---------------------------------------------------------------------------
// sacm_acc_if / sacm_res_if: access and result channels
// Valid/ready handshake with the payload of one word.
// ---------------------------------------------------------------------------
interface sacm_acc_if #(parameter int SET_W = 8, parameter int TAG_WIDTH = 48);
  logic                 valid;
  logic                 ready;
  logic                 is_write;
  logic [SET_W-1:0]     set_index;
  logic [TAG_WIDTH-1:0] tag;
  modport source (output valid, is_write, set_index, tag, input ready);
  modport sink   (input valid, is_write, set_index, tag, output ready);
endinterface

interface sacm_res_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [2:0]  way_used;
  logic [31:0] read_count;
  logic [31:0] write_count;
  logic [31:0] hit_count;
  logic [31:0] miss_count;
  modport source (output valid, hit, way_used, read_count, write_count, hit_count,
                  miss_count, input ready);
  modport sink   (input valid, hit, way_used, read_count, write_count, hit_count,
                  miss_count, output ready);
endinterface

/* hdl/sacm_ram.sv */
// ---------------------------------------------------------------------------
// sacm_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ---------------------------------------------------------------------------
module sacm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* hdl/sacm_front.sv */
// ---------------------------------------------------------------------------
// sacm_front: access intake queue
// Accept access words, resize the set index and hold them in a two-entry queue.
// ---------------------------------------------------------------------------
module sacm_front #(
  parameter int TAG_W  = 48,
  parameter int SIDX_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  sacm_acc_if.sink          acc,
  output logic              q_valid,
  input  logic              q_pop,
  output logic              q_is_write,
  output logic [SIDX_W-1:0] q_set,
  output logic [TAG_W-1:0]  q_tag
);
  localparam int ENT_W = 1 + SIDX_W + TAG_W;
  logic [ENT_W-1:0] ent_r [2];
  logic             rd_ptr_r, wr_ptr_r;
  logic [1:0]       cnt_r;
  logic             push;

  assign acc.ready = (cnt_r != 2'd2);
  assign push      = acc.valid & acc.ready;
  assign q_valid   = (cnt_r != 2'd0);
  assign {q_is_write, q_set, q_tag} = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= {acc.is_write, SIDX_W'(acc.set_index), acc.tag};
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push)  wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !acc.ready) else $error("accept while full");
endmodule

/* hdl/sacm_back.sv */
// ---------------------------------------------------------------------------
// sacm_back: tag lookup and update engine
// Clear all set rows after reset; then read a set row, pick the way, write the row back and post the result.
// ---------------------------------------------------------------------------
module sacm_back
  import sacm_pkg::*;
#(
  parameter int SIDX_W   = 8,
  parameter int TAG_W    = 48,
  parameter int MAX_WAYS = 8,
  parameter int NUM_SETS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  logic              q_is_write,
  input  logic [SIDX_W-1:0] q_set,
  input  logic [TAG_W-1:0]  q_tag,
  input  logic              mode,
  input  logic [3:0]        ways_in_use,
  sacm_res_if.source        res
);
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TA_W  = MAX_WAYS * (TAG_W + CNT_W);
  localparam int ROW_W = TA_W + MAX_WAYS;
  localparam int NW_W  = $clog2(MAX_WAYS + 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [SIDX_W-1:0]  clr_r, set_r;
  logic [TAG_W-1:0]   tag_r;
  logic               wr_r;
  logic [CNT_W-1:0]   rd_cnt_r, wr_cnt_r, hit_cnt_r, miss_cnt_r;
  logic               hit_r;
  logic [WAY_W-1:0]   way_r;

  logic               ram_we;
  logic [SIDX_W-1:0]  ram_addr;
  logic [ROW_W-1:0]   ram_wdata, ram_rdata;

  // row layout: per-way tag and age, valid bits on top
  sacm_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata));

  // active way count, clamped to 1..MAX_WAYS
  logic [NW_W-1:0] nways;
  always_comb begin
    if (ways_in_use == 4'd0) nways = NW_W'(1);
    else if ({1'b0, ways_in_use} > 5'(MAX_WAYS)) nways = NW_W'(MAX_WAYS);
    else nways = NW_W'(ways_in_use);
  end

  // row decode and way selection
  logic [TAG_W-1:0] row_tag [MAX_WAYS];
  logic [CNT_W-1:0] row_age [MAX_WAYS];
  logic [MAX_WAYS-1:0] vrow;
  logic             lk_hit, lk_found;
  logic [WAY_W-1:0] lk_way, vict;
  logic [CNT_W-1:0] max_age, new_age;
  always_comb begin
    vrow     = ram_rdata[TA_W +: MAX_WAYS];
    lk_hit   = 1'b0;
    lk_found = 1'b0;
    lk_way   = '0;
    vict     = '0;
    max_age  = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      row_tag[i] = ram_rdata[i*(TAG_W+CNT_W) +: TAG_W];
      row_age[i] = vrow[i] ? ram_rdata[i*(TAG_W+CNT_W)+TAG_W +: CNT_W] : '0;
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (NW_W'(i) < nways) begin
        if (!lk_found) begin
          if (!vrow[i]) begin
            lk_found = 1'b1;
            lk_way   = WAY_W'(i);
          end else if (row_tag[i] == tag_r) begin
            lk_found = 1'b1;
            lk_hit   = 1'b1;
            lk_way   = WAY_W'(i);
          end
        end
        if (row_age[i] >= max_age) max_age = row_age[i];
        if (row_age[i] <= row_age[vict]) vict = WAY_W'(i);
      end
    end
    if (!lk_found) lk_way = vict;
    new_age = sat_inc(max_age);
  end

  // write-back row; an all-zero row during the clearing pass
  always_comb begin
    ram_wdata = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      ram_wdata[i*(TAG_W+CNT_W) +: TAG_W]         = row_tag[i];
      ram_wdata[i*(TAG_W+CNT_W)+TAG_W +: CNT_W]   = row_age[i];
      ram_wdata[TA_W+i]                           = vrow[i];
      if (WAY_W'(i) == lk_way) begin
        ram_wdata[TA_W+i] = 1'b1;
        if (!lk_hit) ram_wdata[i*(TAG_W+CNT_W) +: TAG_W] = tag_r;
        if (!lk_hit || mode == MODE_LRU)
          ram_wdata[i*(TAG_W+CNT_W)+TAG_W +: CNT_W] = new_age;
      end
    end
    if (state_r == ST_CLEAR) ram_wdata = '0;
  end

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign ram_we   = (state_r == ST_LOOK) || (state_r == ST_CLEAR);
  assign ram_addr = (state_r == ST_CLEAR) ? clr_r :
                    (state_r == ST_IDLE)  ? q_set : set_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == SIDX_W'(NUM_SETS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (q_valid) state_nxt = ST_LOOK;
      ST_LOOK:  state_nxt = ST_OUT;
      ST_OUT:   if (res.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      set_r <= q_set;
      tag_r <= q_tag;
      wr_r  <= q_is_write;
    end
    if (state_r == ST_LOOK) begin
      hit_r <= lk_hit;
      way_r <= lk_way;
    end
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_r      <= '0;
      rd_cnt_r   <= '0;
      wr_cnt_r   <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == ST_LOOK) begin
        if (wr_r) wr_cnt_r <= sat_inc(wr_cnt_r);
        if (lk_hit) hit_cnt_r <= sat_inc(hit_cnt_r);
        else begin
          rd_cnt_r   <= sat_inc(rd_cnt_r);
          miss_cnt_r <= sat_inc(miss_cnt_r);
        end
      end
    end
  end

  assign res.valid       = (state_r == ST_OUT);
  assign res.hit         = hit_r;
  assign res.way_used    = 3'(way_r);
  assign res.read_count  = rd_cnt_r;
  assign res.write_count = wr_cnt_r;
  assign res.hit_count   = hit_cnt_r;
  assign res.miss_count  = miss_cnt_r;

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_miss_read: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (rd_cnt_r == miss_cnt_r)) else $error("read and miss counts differ");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res.ready) |=> (res.valid && $stable(way_r)))
    else $error("result dropped under stall");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_LOOK)) else $error("pop without lookup");
endmodule

/* hdl/set_assoc_cache_model.sv */
// ---------------------------------------------------------------------------
// set_assoc_cache_model: set-associative tag store with LRU/FIFO replacement
// Front intake queue plus a back lookup engine over one row RAM.
// ---------------------------------------------------------------------------
// Usage:
//   acc: one access word per handshake (is_write, set_index, tag).
//   res: one result word per access (hit, way_used and four running counts).
//   cfg: write port; index 0 replace_mode (0 FIFO, 1 LRU), index 1
//        ways_in_use. Write only while no access is in flight.
// Timing: the back engine reads the set row while idle, then selects the
//   way and writes the row back in the next cycle; the result is then held
//   in the output state until taken. An access passes through the row read,
//   the update with write-back and the result, and the engine takes no new
//   access until its result is taken. A two-word queue keeps accepting while a result waits.
// Reset: counters clear, config returns to LRU with 8 ways, and a clearing
//   pass writes zeros to all NUM_SETS set rows; the queue may fill during
//   it but no lookup starts until it ends.
// Stall: a result not taken holds the engine; the queue then fills and
//   acc.ready drops.
// ---------------------------------------------------------------------------
module set_assoc_cache_model
  import sacm_pkg::*;
#(
  parameter int NUM_SETS  = 256,
  parameter int MAX_WAYS  = 8,
  parameter int TAG_WIDTH = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sacm_acc_if.sink             in_acc,
  sacm_res_if.source           out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);
  localparam int SIDX_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  logic       mode_r;
  logic [3:0] ways_r;

  // hold config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LRU;
      ways_r <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPLACE_MODE: mode_r <= cfg_wdata[0];
        CFG_WAYS_IN_USE:  ways_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic              q_valid, q_pop, q_is_write;
  logic [SIDX_W-1:0] q_set;
  logic [TAG_WIDTH-1:0] q_tag;

  sacm_front #(.TAG_W(TAG_WIDTH), .SIDX_W(SIDX_W)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(in_acc),
    .q_valid(q_valid), .q_pop(q_pop), .q_is_write(q_is_write),
    .q_set(q_set), .q_tag(q_tag));

  sacm_back #(.SIDX_W(SIDX_W), .TAG_W(TAG_WIDTH), .MAX_WAYS(MAX_WAYS),
              .NUM_SETS(NUM_SETS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
    .q_is_write(q_is_write), .q_set(q_set), .q_tag(q_tag),
    .mode(mode_r), .ways_in_use(ways_r), .res(out_res));
endmodule

/* tb/set_assoc_cache_model_tb.sv */
// ---------------------------------------------------------------------------
// set_assoc_cache_model_tb: self-checking bench for the cache tag model
// Drives access words with random gaps and stalls, predicts each result from
// a private copy of the tag store and counters, and compares field by field.
// ---------------------------------------------------------------------------
module set_assoc_cache_model_tb;
  import sacm_pkg::*;

  localparam int NSETS = 256;
  localparam int NWAYS = 8;
  localparam int TAGW  = 48;

  typedef struct packed {
    logic            is_write;
    logic [7:0]      set_index;
    logic [TAGW-1:0] tag;
  } access_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  way_used;
    logic [31:0] read_count;
    logic [31:0] write_count;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
  } lookup_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  sacm_acc_if #(.SET_W(8), .TAG_WIDTH(TAGW)) acc_ch ();
  sacm_res_if res_ch ();

  set_assoc_cache_model #(.NUM_SETS(NSETS), .MAX_WAYS(NWAYS), .TAG_WIDTH(TAGW)) uut (
    .clk(clk), .rst_n(rst_n), .in_acc(acc_ch.sink), .out_res(res_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the tag store, counters and config.
  logic [TAGW-1:0] shadow_tag   [NSETS*NWAYS];
  logic            shadow_valid [NSETS*NWAYS];
  logic [31:0]     shadow_age   [NSETS*NWAYS];
  logic [31:0]     reads_seen, writes_seen, hits_seen, misses_seen;
  logic            lru_mode;
  logic [3:0]      ways_cfg;

  access_t pending_words[$];
  lookup_t expected_lookups[$];
  int      errors;
  int      hold_off_cycles;

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Compute the result of one access and update the shadow state.
  function automatic lookup_t predict_lookup(access_t a);
    lookup_t r;
    int nw, base, way, e;
    logic hit, placed;
    logic [31:0] top;
    nw = (ways_cfg < 1) ? 1 : (ways_cfg > NWAYS) ? NWAYS : ways_cfg;
    base = a.set_index * NWAYS;
    way = 0;
    hit = 0;
    placed = 0;
    if (a.is_write) writes_seen = bump(writes_seen);
    for (int i = 0; i < nw; i++) begin
      if (!hit && !placed) begin
        if (!shadow_valid[base+i]) begin
          way = i;
          placed = 1;
        end else if (shadow_tag[base+i] == a.tag) begin
          way = i;
          hit = 1;
        end
      end
    end
    // Victim: smallest age, last way wins a tie.
    if (!hit && !placed) begin
      way = 0;
      for (int i = 0; i < nw; i++)
        if (shadow_age[base+i] <= shadow_age[base+way]) way = i;
    end
    top = shadow_age[base];
    for (int i = 1; i < nw; i++)
      if (shadow_age[base+i] >= top) top = shadow_age[base+i];
    e = base + way;
    if (hit) begin
      hits_seen = bump(hits_seen);
      if (lru_mode == MODE_LRU) shadow_age[e] = bump(top);
    end else begin
      reads_seen = bump(reads_seen);
      misses_seen = bump(misses_seen);
      shadow_valid[e] = 1'b1;
      shadow_tag[e] = a.tag;
      shadow_age[e] = bump(top);
    end
    r.hit = hit;
    r.way_used = way[2:0];
    r.read_count = reads_seen;
    r.write_count = writes_seen;
    r.hit_count = hits_seen;
    r.miss_count = misses_seen;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: offer queued words, with random gaps between them.
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      acc_ch.valid <= 1'b0;
      gap_left <= 0;
    end else if (acc_ch.valid && !acc_ch.ready) begin
      // hold the word until taken
    end else begin
      if (acc_ch.valid) expected_lookups.push_back(predict_lookup(
          access_t'{acc_ch.is_write, acc_ch.set_index, acc_ch.tag}));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        acc_ch.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        access_t w;
        w = pending_words.pop_front();
        acc_ch.valid <= 1'b1;
        acc_ch.is_write <= w.is_write;
        acc_ch.set_index <= w.set_index;
        acc_ch.tag <= w.tag;
        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(3, 20) :
                    ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : 0;
      end else begin
        acc_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: take results with random stalls and check each one.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        lookup_t got, want;
        got = {res_ch.hit, res_ch.way_used, res_ch.read_count, res_ch.write_count,
               res_ch.hit_count, res_ch.miss_count};
        if (expected_lookups.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_lookups.pop_front();
          if (got.hit != want.hit || got.way_used != want.way_used ||
              got.read_count != want.read_count || got.write_count != want.write_count ||
              got.hit_count != want.hit_count || got.miss_count != want.miss_count) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left <= ($urandom_range(0, 11) == 0) ? $urandom_range(3, 25) :
                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      end
    end
  end

  // Wait until every queued word is accepted and every result checked.
  // Sample between edges so that a word just launched is seen as valid.
  task automatic drain();
    while (pending_words.size() > 0 || acc_ch.valid || expected_lookups.size() > 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_REPLACE_MODE) lru_mode = val[0];
    else ways_cfg = val;
    @(posedge clk);
  endtask

  function automatic access_t make_access(logic w, logic [7:0] s, logic [TAGW-1:0] t);
    access_t a;
    a.is_write = w;
    a.set_index = s;
    a.tag = t;
    return a;
  endfunction

  // Random phase: mostly a small hot pool of sets and tags to force hits and
  // evictions, plus some fully random words.
  task automatic random_phase(int count);
    access_t a;
    for (int i = 0; i < count; i++) begin
      a.is_write = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) != 0) begin
        a.set_index = 8'($urandom_range(0, 3) * 85);
        a.tag = {$urandom, 16'h0} ^ TAGW'($urandom_range(0, 11));
        a.tag[TAGW-1:16] = {32{a.tag[0]}};
      end else begin
        a.set_index = 8'($urandom_range(0, 255));
        a.tag = TAGW'({$urandom, $urandom});
      end
      pending_words.push_back(a);
    end
  endtask

  initial begin
    errors = 0;
    hold_off_cycles = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_REPLACE_MODE;
    cfg_wdata = '0;
    acc_ch.valid = 1'b0;
    acc_ch.is_write = 1'b0;
    acc_ch.set_index = '0;
    acc_ch.tag = '0;
    res_ch.ready = 1'b0;
    lru_mode = MODE_LRU;
    ways_cfg = 4'd8;
    reads_seen = 0;
    writes_seen = 0;
    hits_seen = 0;
    misses_seen = 0;
    for (int i = 0; i < NSETS*NWAYS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_age[i] = '0;
      shadow_tag[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, fill a set, hit, then evict in LRU mode.
    pending_words.push_back(make_access(1'b0, 8'd0, '0));
    pending_words.push_back(make_access(1'b1, 8'd255, {TAGW{1'b1}}));
    pending_words.push_back(make_access(1'b1, 8'd255, {TAGW{1'b1}}));
    for (int i = 0; i < 9; i++)
      pending_words.push_back(make_access(i[0], 8'd7, TAGW'(i + 100)));
    pending_words.push_back(make_access(1'b0, 8'd7, TAGW'(102)));
    pending_words.push_back(make_access(1'b0, 8'd7, TAGW'(500)));
    drain();

    // FIFO with one way, then the all-zero ways value (acts as one).
    write_reg(CFG_REPLACE_MODE, {3'b0, MODE_FIFO});
    write_reg(CFG_WAYS_IN_USE, 4'd1);
    pending_words.push_back(make_access(1'b0, 8'd9, TAGW'(1)));
    pending_words.push_back(make_access(1'b0, 8'd9, TAGW'(1)));
    pending_words.push_back(make_access(1'b1, 8'd9, TAGW'(2)));
    drain();
    write_reg(CFG_WAYS_IN_USE, 4'd0);
    pending_words.push_back(make_access(1'b0, 8'd9, TAGW'(2)));
    drain();

    // Out-of-range ways count (acts as eight) with FIFO, then random phases.
    write_reg(CFG_WAYS_IN_USE, 4'd15);
    random_phase(200);
    drain();

    write_reg(CFG_REPLACE_MODE, {3'b0, MODE_LRU});
    write_reg(CFG_WAYS_IN_USE, 4'd3);
    // Long receiver hold-off while the sender keeps offering.
    hold_off_cycles = 200;
    random_phase(220);
    drain();

    write_reg(CFG_REPLACE_MODE, {3'b0, MODE_FIFO});
    write_reg(CFG_WAYS_IN_USE, 4'd4);
    random_phase(200);
    drain();

    write_reg(CFG_REPLACE_MODE, {3'b0, MODE_LRU});
    write_reg(CFG_WAYS_IN_USE, 4'd8);
    random_phase(200);
    drain();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
